@@ rtl/core/sosf_pkg.sv @@
// Shared types, constants and codes for the sum-of-sinusoids fading generator.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package sosf_pkg;

    localparam int MAX_PATHS = 16;
    localparam int LUT_BITS  = 16;

    localparam int ANGLE_W  = 16;
    localparam int IDX_W    = 4;
    localparam int TIME_W   = 32;
    localparam int STEP_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int GAIN_W   = 16;
    localparam int FADE_W   = 18;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int ROM_SIZE = 1 << LUT_BITS;
    localparam int QROM_SIZE = ROM_SIZE / 4 + 1;
    localparam int QJ_W = LUT_BITS - 1;
    localparam int PATH_AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
    localparam int PCNT_W = $clog2(MAX_PATHS + 1);
    localparam int SUM_W = WORD_W + $clog2(MAX_PATHS);
    localparam int ENTRY_W = 3 * ANGLE_W;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

    localparam logic [STEP_W-1:0]  DOPPLER_RST = '0;
    localparam logic [COUNT_W-1:0] PATHS_RST   = 5'd8;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 16'd11585;

    localparam logic [CFG_IDX_W-1:0] REG_DOPPLER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATHS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef logic signed [WORD_W-1:0] rom_word_t;
    typedef logic [LUT_BITS-1:0]      lut_idx_t;
    typedef logic signed [FADE_W-1:0] fade_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam fade_t FADE_MAX = 18'sh1FFFF;
    localparam fade_t FADE_MIN = -18'sh20000;

    typedef struct packed {
        logic            neg;
        logic [QJ_W-1:0] j;
    } rom_addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_HOLD
    } sosf_state_t;

endpackage

`default_nettype wire

@@ rtl/core/sosf_if.sv @@
// Channel interfaces: sample/load requests, fade results and register writes.
// Depends on sosf_pkg for field widths.
`default_nettype none

interface sosf_req_if import sosf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [IDX_W-1:0]    path_index;
    logic [ANGLE_W-1:0]  arrival_angle;
    logic [ANGLE_W-1:0]  phase_i;
    logic [ANGLE_W-1:0]  phase_q;
    logic [TIME_W-1:0]   sample_time;

    modport source (output valid, kind, path_index, arrival_angle, phase_i, phase_q,
                    sample_time, input ready);
    modport sink   (input valid, kind, path_index, arrival_angle, phase_i, phase_q,
                    sample_time, output ready);
endinterface

interface sosf_rsp_if import sosf_pkg::*; ();
    logic  valid;
    logic  ready;
    fade_t fade_i;
    fade_t fade_q;

    modport source (output valid, fade_i, fade_q, input ready);
    modport sink   (input valid, fade_i, fade_q, output ready);
endinterface

interface sosf_cfg_if import sosf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sosf_cos_rom.sv @@
// Dual-port synchronous cosine ROM: quarter-wave table with symmetry folding.
// Reads are registered. Depends on sosf_pkg.
`default_nettype none

module sosf_cos_rom import sosf_pkg::*;
(
    input  wire       clk,
    input  lut_idx_t  idx_a,
    input  lut_idx_t  idx_b,
    output rom_word_t word_a,
    output rom_word_t word_b
);

    localparam int HALF    = ROM_SIZE / 2;
    localparam int QUARTER = ROM_SIZE / 4;
    localparam int EIGHTH  = ROM_SIZE / 8;

    rom_word_t qtab [QROM_SIZE];
    rom_addr_t addr_a;
    rom_addr_t addr_b;
    rom_word_t word_a_reg;
    rom_word_t word_b_reg;
    logic      neg_a_reg;
    logic      neg_b_reg;

    function automatic rom_addr_t fold(input lut_idx_t k);
        logic [LUT_BITS:0] kk;
        rom_addr_t         r;
        kk    = {1'b0, k};
        r.neg = 1'b0;
        if (kk > (LUT_BITS+1)'(HALF))
            kk = (LUT_BITS+1)'(ROM_SIZE) - kk;
        if (kk > (LUT_BITS+1)'(QUARTER))
        begin
            kk    = (LUT_BITS+1)'(HALF) - kk;
            r.neg = 1'b1;
        end
        r.j = kk[QJ_W-1:0];
        return r;
    endfunction

    function automatic logic [63:0] step_term(input logic [63:0] t, input logic [63:0] x2);
        return (t * x2) >> 30;
    endfunction

    function automatic logic [63:0] q30_angle(input int j);
        return (64'(j) * TWO_PI_Q30 + 64'(HALF)) >> LUT_BITS;
    endfunction

    function automatic logic [63:0] series_cos(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x2  = (x * x) >> 30;
        t   = 64'd1 << 30;
        acc = $signed(t);
        t = step_term(t, x2) / 64'd2;   acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd12;  acc = acc + $signed(t);
        t = step_term(t, x2) / 64'd30;  acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd56;  acc = acc + $signed(t);
        t = step_term(t, x2) / 64'd90;  acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd132; acc = acc + $signed(t);
        t = step_term(t, x2) / 64'd182; acc = acc - $signed(t);
        return (acc < 0) ? 64'd0 : $unsigned(acc);
    endfunction

    function automatic logic [63:0] series_sin(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x2  = (x * x) >> 30;
        t   = x;
        acc = $signed(t);
        t = step_term(t, x2) / 64'd6;   acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd20;  acc = acc + $signed(t);
        t = step_term(t, x2) / 64'd42;  acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd72;  acc = acc + $signed(t);
        t = step_term(t, x2) / 64'd110; acc = acc - $signed(t);
        t = step_term(t, x2) / 64'd156; acc = acc + $signed(t);
        return (acc < 0) ? 64'd0 : $unsigned(acc);
    endfunction

    function automatic rom_word_t rom_entry(input int j);
        logic [63:0] v;
        logic [63:0] r;
        if (j <= EIGHTH)
            v = series_cos(q30_angle(j));
        else
            v = series_sin(q30_angle(QUARTER - j));
        r = (v + 64'd32768) >> 16;
        return rom_word_t'(r[WORD_W-1:0]);
    endfunction

    always_comb
    begin
        for (int j = 0; j < QROM_SIZE; j++)
            qtab[j] = rom_entry(j);
    end

    assign addr_a = fold(idx_a);
    assign addr_b = fold(idx_b);

    always_ff @(posedge clk)
    begin
        word_a_reg <= qtab[addr_a.j];
        word_b_reg <= qtab[addr_b.j];
        neg_a_reg  <= addr_a.neg;
        neg_b_reg  <= addr_b.neg;
    end

    assign word_a = neg_a_reg ? -word_a_reg : word_a_reg;
    assign word_b = neg_b_reg ? -word_b_reg : word_b_reg;

endmodule

`default_nettype wire

@@ rtl/core/sosf_phase_calc.sv @@
// Two-stage phase datapath: Doppler times direction cosine, times sample time,
// plus phase offset; yields the cosine ROM index for I and Q. Depends on sosf_pkg.
`default_nettype none

module sosf_phase_calc import sosf_pkg::*;
(
    input  wire                 clk,
    input  wire [STEP_W-1:0]    doppler,
    input  wire [TIME_W-1:0]    t,
    input  rom_word_t           dir_i,
    input  rom_word_t           dir_q,
    input  wire [ANGLE_W-1:0]   off_i,
    input  wire [ANGLE_W-1:0]   off_q,
    output lut_idx_t            idx_i,
    output lut_idx_t            idx_q
);

    logic signed [STEP_W+WORD_W:0] pc_i_full;
    logic signed [STEP_W+WORD_W:0] pc_q_full;
    logic [45:0]                   pc_i_reg;
    logic [45:0]                   pc_q_reg;
    logic [ANGLE_W-1:0]            off_i_a_reg;
    logic [ANGLE_W-1:0]            off_q_a_reg;

    logic [63:0]                   pl_i_full;
    logic [63:0]                   pl_q_full;
    logic [27:0]                   ph_i_full;
    logic [27:0]                   ph_q_full;
    logic [31:0]                   pl_i_reg;
    logic [31:0]                   pl_q_reg;
    logic [13:0]                   ph_i_reg;
    logic [13:0]                   ph_q_reg;
    logic [ANGLE_W-1:0]            off_i_b_reg;
    logic [ANGLE_W-1:0]            off_q_b_reg;

    logic [31:0]                   phase_i;
    logic [31:0]                   phase_q;

    assign pc_i_full = $signed({1'b0, doppler}) * dir_i;
    assign pc_q_full = $signed({1'b0, doppler}) * dir_q;

    always_ff @(posedge clk)
    begin
        pc_i_reg    <= pc_i_full[45:0];
        pc_q_reg    <= pc_q_full[45:0];
        off_i_a_reg <= off_i;
        off_q_a_reg <= off_q;
    end

    // split the 46-bit rate so each multiplier operand stays within 32 bits
    assign pl_i_full = pc_i_reg[31:0] * t;
    assign pl_q_full = pc_q_reg[31:0] * t;
    assign ph_i_full = pc_i_reg[45:32] * t[13:0];
    assign ph_q_full = pc_q_reg[45:32] * t[13:0];

    always_ff @(posedge clk)
    begin
        pl_i_reg    <= pl_i_full[45:14];
        pl_q_reg    <= pl_q_full[45:14];
        ph_i_reg    <= ph_i_full[13:0];
        ph_q_reg    <= ph_q_full[13:0];
        off_i_b_reg <= off_i_a_reg;
        off_q_b_reg <= off_q_a_reg;
    end

    assign phase_i = pl_i_reg + {ph_i_reg, 18'b0} + {off_i_b_reg, 16'b0};
    assign phase_q = pl_q_reg + {ph_q_reg, 18'b0} + {off_q_b_reg, 16'b0};

    assign idx_i = phase_i[31 -: LUT_BITS];
    assign idx_q = phase_q[31 -: LUT_BITS];

endmodule

`default_nettype wire

@@ rtl/core/sosf_scale.sv @@
// Output scaler: registered gain multiply, then round and saturate to Q2.15.
// Depends on sosf_pkg.
`default_nettype none

module sosf_scale import sosf_pkg::*;
(
    input  wire              clk,
    input  sum_t             sum,
    input  wire [GAIN_W-1:0] gain,
    output fade_t            fade
);

    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam logic signed [PROD_W:0] SAT_HI = (PROD_W+1)'(FADE_MAX);
    localparam logic signed [PROD_W:0] SAT_LO = (PROD_W+1)'(FADE_MIN);
    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(8192);

    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W:0]   rounded;
    logic signed [PROD_W:0]   shifted;

    assign prod_full = sum * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
    end

    assign rounded = $signed({prod_reg[PROD_W-1], prod_reg}) + ROUND_HALF;
    assign shifted = rounded >>> 14;

    always_comb
    begin
        if (shifted > SAT_HI)
            fade = FADE_MAX;
        else if (shifted < SAT_LO)
            fade = FADE_MIN;
        else
            fade = fade_t'(shifted[FADE_W-1:0]);
    end

endmodule

`default_nettype wire

@@ rtl/core/sum_of_sinusoids_fading_gen.sv @@
// Rayleigh fading gain generator by a sum of sinusoids. A load transfer writes one path
// entry. A sample transfer walks min(path_count, 16) paths, one path-table read per
// cycle, through a five-stage pipeline (path read, angle cosine/sine lookup, two multiply
// stages, phase cosine lookup), then scales; no new transfer is taken until its result
// is in the output register. The cosine ROM is a fixed quarter-wave table and needs no
// fill after reset. A finished result waits in the output register while the next
// transfer is taken.
// Depends on sosf_pkg, sosf_if, sosf_cos_rom, sosf_phase_calc and sosf_scale.
`default_nettype none

module sum_of_sinusoids_fading_gen import sosf_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    sosf_cfg_if.sink    cfg,
    sosf_req_if.sink    req,
    sosf_rsp_if.source  rsp
);

    sosf_state_t state_reg, state_next;

    logic [STEP_W-1:0]  doppler_reg, doppler_next;
    logic [COUNT_W-1:0] paths_reg, paths_next;
    logic [GAIN_W-1:0]  gain_reg, gain_next;

    logic [PCNT_W-1:0]  p_reg, p_next;
    logic [PCNT_W-1:0]  n_reg, n_next;
    logic [PCNT_W-1:0]  n_eff;
    logic [5:1]         pipe_v_reg, pipe_v_next;
    logic               out_valid_reg, out_valid_next;
    fade_t              fade_i_reg, fade_i_next;
    fade_t              fade_q_reg, fade_q_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    sum_t               sum_i_reg, sum_i_next;
    sum_t               sum_q_reg, sum_q_next;

    logic [ENTRY_W-1:0] path_mem [MAX_PATHS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ANGLE_W-1:0] off_i_reg;
    logic [ANGLE_W-1:0] off_q_reg;

    logic               req_xfer;
    logic               accept_sample;
    logic               mem_we;
    logic               issue;
    logic               out_free;
    logic               load_out;
    logic               in_ready;

    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] angle_sin;
    rom_word_t          dir_c;
    rom_word_t          dir_s;
    lut_idx_t           ph_idx_i;
    lut_idx_t           ph_idx_q;
    rom_word_t          ph_word_i;
    rom_word_t          ph_word_q;
    fade_t              scaled_i;
    fade_t              scaled_q;

    // configuration
    assign cfg.ready = 1'b1;

    always_comb
    begin
        doppler_next = doppler_reg;
        paths_next   = paths_reg;
        gain_next    = gain_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DOPPLER: doppler_next = cfg.data;
                REG_PATHS:   paths_next   = cfg.data[COUNT_W-1:0];
                REG_GAIN:    gain_next    = cfg.data[GAIN_W-1:0];
                default:     doppler_next = doppler_reg;
            endcase
        end
    end

    // handshake decode
    assign req.ready     = in_ready;
    assign req_xfer      = req.valid && in_ready;
    assign accept_sample = req_xfer && (req.kind == KIND_SAMPLE);
    assign mem_we        = req_xfer && (req.kind == KIND_LOAD)
                           && (32'(req.path_index) < MAX_PATHS);
    assign out_free      = !out_valid_reg || rsp.ready;
    assign n_eff = (32'(paths_reg) < MAX_PATHS) ? PCNT_W'(paths_reg) : PCNT_W'(MAX_PATHS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample)
                    state_next = (n_eff == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                if (PCNT_W'(p_reg + 1'b1) == n_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_v_reg == '0)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
                state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_HOLD:  load_out = out_free;
            default:  in_ready = 1'b0;
        endcase
    end

    // sequencing and accumulation
    always_comb
    begin
        p_next         = p_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        sum_i_next     = sum_i_reg;
        sum_q_next     = sum_q_reg;
        pipe_v_next    = {pipe_v_reg[4:1], issue};
        out_valid_next = out_valid_reg;
        fade_i_next    = fade_i_reg;
        fade_q_next    = fade_q_reg;

        if (accept_sample)
        begin
            p_next     = '0;
            n_next     = n_eff;
            t_next     = req.sample_time;
            sum_i_next = '0;
            sum_q_next = '0;
        end
        else
        begin
            if (issue)
                p_next = PCNT_W'(p_reg + 1'b1);
            if (pipe_v_reg[5])
            begin
                sum_i_next = sum_i_reg + SUM_W'(ph_word_i);
                sum_q_next = sum_q_reg + SUM_W'(ph_word_q);
            end
        end

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            fade_i_next    = scaled_i;
            fade_q_next    = scaled_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            doppler_reg   <= DOPPLER_RST;
            paths_reg     <= PATHS_RST;
            gain_reg      <= GAIN_RST;
            p_reg         <= '0;
            n_reg         <= '0;
            pipe_v_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            doppler_reg   <= doppler_next;
            paths_reg     <= paths_next;
            gain_reg      <= gain_next;
            p_reg         <= p_next;
            n_reg         <= n_next;
            pipe_v_reg    <= pipe_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        sum_i_reg  <= sum_i_next;
        sum_q_reg  <= sum_q_next;
        fade_i_reg <= fade_i_next;
        fade_q_reg <= fade_q_next;
    end

    // path table
    always_ff @(posedge clk)
    begin
        if (mem_we)
            path_mem[PATH_AW'(req.path_index)] <= {req.arrival_angle, req.phase_i, req.phase_q};
        if (issue)
            rd_data_reg <= path_mem[PATH_AW'(p_reg)];
    end

    assign angle     = rd_data_reg[ENTRY_W-1 -: ANGLE_W];
    assign angle_sin = angle - QUARTER_TURN;

    always_ff @(posedge clk)
    begin
        off_i_reg <= rd_data_reg[2*ANGLE_W-1 -: ANGLE_W];
        off_q_reg <= rd_data_reg[ANGLE_W-1:0];
    end

    sosf_cos_rom u_dir_rom (
        .clk    (clk),
        .idx_a  (angle[ANGLE_W-1 -: LUT_BITS]),
        .idx_b  (angle_sin[ANGLE_W-1 -: LUT_BITS]),
        .word_a (dir_c),
        .word_b (dir_s)
    );

    sosf_phase_calc u_phase (
        .clk     (clk),
        .doppler (doppler_reg),
        .t       (t_reg),
        .dir_i   (dir_c),
        .dir_q   (dir_s),
        .off_i   (off_i_reg),
        .off_q   (off_q_reg),
        .idx_i   (ph_idx_i),
        .idx_q   (ph_idx_q)
    );

    sosf_cos_rom u_phase_rom (
        .clk    (clk),
        .idx_a  (ph_idx_i),
        .idx_b  (ph_idx_q),
        .word_a (ph_word_i),
        .word_b (ph_word_q)
    );

    sosf_scale u_scale_i (
        .clk  (clk),
        .sum  (sum_i_reg),
        .gain (gain_reg),
        .fade (scaled_i)
    );

    sosf_scale u_scale_q (
        .clk  (clk),
        .sum  (sum_q_reg),
        .gain (gain_reg),
        .fade (scaled_q)
    );

    assign rsp.valid  = out_valid_reg;
    assign rsp.fade_i = fade_i_reg;
    assign rsp.fade_q = fade_q_reg;

    a_no_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !issue && (pipe_v_reg == '0))
        else $error("path table written while a sample is in flight");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |=> (sum_i_reg == '0) && (sum_q_reg == '0))
        else $error("accumulators not cleared at sample start");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_SCALE) |-> (pipe_v_reg == '0))
        else $error("pipeline not empty outside the walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (p_reg < n_reg))
        else $error("path counter ran past the active path count");

endmodule

`default_nettype wire

@@ test/sum_of_sinusoids_fading_gen_tb.sv @@
// Self-checking bench for sum_of_sinusoids_fading_gen: path loads and fade samples under
// random stalls, each result checked against an in-bench fixed-point fade predictor.
// Depends on sosf_pkg, the sosf_if channel interfaces and the RTL in rtl/core.

module sum_of_sinusoids_fading_gen_tb;
    import sosf_pkg::*;

    localparam logic [63:0] TURN_Q30 = 64'd6746518852;
    localparam int N_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 40;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic                kind;
        logic [IDX_W-1:0]    idx;
        logic [ANGLE_W-1:0]  angle;
        logic [ANGLE_W-1:0]  off_i;
        logic [ANGLE_W-1:0]  off_q;
        logic [TIME_W-1:0]   t;
    } request_t;

    typedef struct {
        fade_t i;
        fade_t q;
    } fade_pair_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] off_i;
        logic [ANGLE_W-1:0] off_q;
    } path_entry_t;

    logic clk;
    logic rst_n;

    sosf_cfg_if cfg_ch ();
    sosf_req_if req_ch ();
    sosf_rsp_if rsp_ch ();

    sum_of_sinusoids_fading_gen u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state
    logic signed [WORD_W-1:0] cos_lut [ROM_SIZE];
    path_entry_t              path_mem [MAX_PATHS];
    logic [STEP_W-1:0]        doppler_q;
    logic [COUNT_W-1:0]       path_cnt_q;
    logic [GAIN_W-1:0]        gain_q;

    request_t   pending_req [$];
    fade_pair_t fade_due [$];
    request_t   on_wire;

    int errors;
    int n_loads;
    int n_samples;
    int results_seen;
    int n_settings;
    int src_gap;
    int sink_gap;
    int hold_left;
    int quiet_cycles;
    int src_pct;
    int sink_pct;
    logic drive_valid;
    logic take_ready;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] q30_angle_of(int unsigned j);
        return (64'(j) * TURN_Q30 + 64'(ROM_SIZE / 2)) >> LUT_BITS;
    endfunction

    function automatic logic [63:0] taylor_sum(logic [63:0] x, bit odd);
        logic [63:0] x2;
        logic [63:0] term;
        longint acc;
        int k0;
        x2 = (x * x) >> 30;
        term = odd ? x : 64'd1 << 30;
        acc = term;
        for (int n = 1; n <= (odd ? 6 : 7); n++)
        begin
            k0 = odd ? 2 * n : 2 * n - 1;
            term = ((term * x2) >> 30) / 64'(k0 * (k0 + 1));
            acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic signed [WORD_W-1:0] lut_entry(int unsigned k);
        int unsigned j;
        bit neg;
        logic [63:0] v;
        int r;
        j = k;
        neg = 1'b0;
        if (j > ROM_SIZE / 2)
            j = ROM_SIZE - j;
        if (j > ROM_SIZE / 4)
        begin
            j = ROM_SIZE / 2 - j;
            neg = 1'b1;
        end
        if (j <= ROM_SIZE / 8)
            v = taylor_sum(q30_angle_of(j), 1'b0);
        else
            v = taylor_sum(q30_angle_of(ROM_SIZE / 4 - j), 1'b1);
        r = int'((v + 64'd32768) >> 16);
        return neg ? WORD_W'(-r) : WORD_W'(r);
    endfunction

    function automatic longint phase_cos(logic signed [WORD_W-1:0] c, logic [TIME_W-1:0] t,
                                         logic [ANGLE_W-1:0] off);
        longint rate;
        logic [63:0] prod;
        logic [31:0] ph;
        rate = longint'({32'd0, doppler_q}) * longint'(c);
        prod = 64'(rate) * {32'd0, t};
        ph = prod[45:14] + {off, 16'd0};
        return longint'(cos_lut[ph[31 -: LUT_BITS]]);
    endfunction

    function automatic fade_t scale_sat(longint s);
        longint y;
        y = (s * longint'({48'd0, gain_q}) + 64'sd8192) >>> 14;
        if (y > 131071)
            return FADE_MAX;
        if (y < -131072)
            return FADE_MIN;
        return y[FADE_W-1:0];
    endfunction

    function automatic fade_pair_t predict_fade(request_t r);
        fade_pair_t f;
        longint sum_i;
        longint sum_q;
        int n;
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] sa;
        sum_i = 0;
        sum_q = 0;
        n = (int'(path_cnt_q) < MAX_PATHS) ? int'(path_cnt_q) : MAX_PATHS;
        for (int p = 0; p < n; p++)
        begin
            a = path_mem[p].angle;
            sa = a - QUARTER_TURN;
            sum_i += phase_cos(cos_lut[a >> (ANGLE_W - LUT_BITS)], r.t, path_mem[p].off_i);
            sum_q += phase_cos(cos_lut[sa >> (ANGLE_W - LUT_BITS)], r.t, path_mem[p].off_q);
        end
        f.i = scale_sat(sum_i);
        f.q = scale_sat(sum_q);
        return f;
    endfunction

    task automatic apply_request(request_t r);
        if (r.kind == KIND_LOAD)
        begin
            if (int'(r.idx) < MAX_PATHS)
                path_mem[r.idx] = '{r.angle, r.off_i, r.off_q};
            n_loads++;
        end
        else
        begin
            fade_due.push_back(predict_fade(r));
            n_samples++;
        end
    endtask

    // source side: hold a pending transfer until taken, otherwise idle in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                apply_request(on_wire);
            if (!(req_ch.valid && !req_ch.ready))
            begin
                drive_valid = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (pending_req.size() > 0 && src_pct > 0
                         && $urandom_range(0, 99) < src_pct)
                    src_gap = $urandom_range(0, 17);
                else if (pending_req.size() > 0)
                begin
                    on_wire = pending_req.pop_front();
                    drive_valid = 1'b1;
                    req_ch.kind <= on_wire.kind;
                    req_ch.path_index <= on_wire.idx;
                    req_ch.arrival_angle <= on_wire.angle;
                    req_ch.phase_i <= on_wire.off_i;
                    req_ch.phase_q <= on_wire.off_q;
                    req_ch.sample_time <= on_wire.t;
                end
                req_ch.valid <= drive_valid;
            end
        end
    end

    // sink side: check each result, stall in bursts, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (fade_due.size() == 0)
                begin
                    $error("unexpected result: fade_i %0d fade_q %0d",
                           rsp_ch.fade_i, rsp_ch.fade_q);
                    errors++;
                end
                else
                begin
                    if (rsp_ch.fade_i !== fade_due[0].i)
                    begin
                        $error("fade_i mismatch: expected %0d, got %0d",
                               fade_due[0].i, rsp_ch.fade_i);
                        errors++;
                    end
                    if (rsp_ch.fade_q !== fade_due[0].q)
                    begin
                        $error("fade_q mismatch: expected %0d, got %0d",
                               fade_due[0].q, rsp_ch.fade_q);
                        errors++;
                    end
                    void'(fade_due.pop_front());
                end
                if (results_seen == HOLD_OFF_AT)
                    hold_left = HOLD_OFF_CYCLES;
            end
            take_ready = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (sink_gap > 0)
                sink_gap--;
            else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct)
                sink_gap = $urandom_range(0, 17);
            else
                take_ready = 1'b1;
            rsp_ch.ready <= take_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    function automatic logic [ANGLE_W-1:0] edge_angle(int k);
        case (k % 8)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h4000;
            3: return 16'h8000;
            4: return 16'hC000;
            5: return 16'h2000;
            6: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        return ($urandom_range(0, 9) == 0) ? edge_angle($urandom_range(0, 7))
                                           : ANGLE_W'($urandom);
    endfunction

    task automatic push_load(int idx, logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] oi,
                             logic [ANGLE_W-1:0] oq);
        request_t r;
        r.kind = KIND_LOAD;
        r.idx = IDX_W'(idx);
        r.angle = a;
        r.off_i = oi;
        r.off_q = oq;
        r.t = TIME_W'($urandom);
        pending_req.push_back(r);
    endtask

    task automatic push_sample(logic [TIME_W-1:0] t);
        request_t r;
        r.kind = KIND_SAMPLE;
        r.idx = IDX_W'($urandom);
        r.angle = ANGLE_W'($urandom);
        r.off_i = ANGLE_W'($urandom);
        r.off_q = ANGLE_W'($urandom);
        r.t = t;
        pending_req.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        if (idx == REG_DOPPLER)
            doppler_q = val[STEP_W-1:0];
        else if (idx == REG_PATHS)
            path_cnt_q = val[COUNT_W-1:0];
        else if (idx == REG_GAIN)
            gain_q = val[GAIN_W-1:0];
    endtask

    task automatic program_regs(logic [STEP_W-1:0] d, logic [COUNT_W-1:0] n,
                                logic [GAIN_W-1:0] g);
        write_reg(REG_DOPPLER, CFG_DATA_W'(d));
        write_reg(REG_PATHS, CFG_DATA_W'(n));
        write_reg(REG_GAIN, CFG_DATA_W'(g));
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // wait until every request is taken and every result is back, then let loads drain
    task automatic settle();
        do @(posedge clk);
        while (pending_req.size() != 0 || req_ch.valid || fade_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 25)
                push_load($urandom_range(0, 15), pick_angle(), pick_angle(), pick_angle());
            else if ($urandom_range(0, 3) == 0)
                push_sample(TIME_W'($urandom_range(0, 255)));
            else if ($urandom_range(0, 19) == 0)
                push_sample($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000);
            else
                push_sample(TIME_W'($urandom));
        end
    endtask

    initial
    begin
        logic [STEP_W-1:0]  dop_list [N_PHASES];
        logic [COUNT_W-1:0] cnt_list [N_PHASES];
        logic [GAIN_W-1:0]  gain_list [N_PHASES];

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_DOPPLER;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOAD;
        req_ch.path_index = '0;
        req_ch.arrival_angle = '0;
        req_ch.phase_i = '0;
        req_ch.phase_q = '0;
        req_ch.sample_time = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        n_loads = 0;
        n_samples = 0;
        results_seen = 0;
        n_settings = 0;
        src_gap = 0;
        sink_gap = 0;
        hold_left = 0;
        quiet_cycles = 0;
        src_pct = 0;
        sink_pct = 0;

        for (int k = 0; k < ROM_SIZE; k++)
            cos_lut[k] = lut_entry(k);
        for (int p = 0; p < MAX_PATHS; p++)
            path_mem[p] = '0;
        doppler_q = DOPPLER_RST;
        path_cnt_q = PATHS_RST;
        gain_q = GAIN_RST;

        dop_list[0] = 32'd0;          cnt_list[0] = 5'd1;  gain_list[0] = 16'd32768;
        dop_list[1] = 32'hFFFF_FFFF;  cnt_list[1] = 5'd16; gain_list[1] = 16'd0;
        dop_list[2] = $urandom;       cnt_list[2] = 5'd0;  gain_list[2] = 16'd11585;
        dop_list[3] = $urandom;       cnt_list[3] = 5'd31; gain_list[3] = 16'hFFFF;
        dop_list[4] = 32'd1;          cnt_list[4] = 5'd16; gain_list[4] = 16'd8192;
        dop_list[5] = $urandom;       cnt_list[5] = 5'd4;  gain_list[5] = 16'd16384;
        dop_list[6] = $urandom;       cnt_list[6] = 5'd17; gain_list[6] = 16'd8192;
        dop_list[7] = 32'h8000_0000;  cnt_list[7] = 5'd8;  gain_list[7] = 16'd11585;
        dop_list[8] = $urandom;       cnt_list[8] = 5'($urandom);
        gain_list[8] = 16'($urandom);
        dop_list[9] = $urandom;       cnt_list[9] = 5'($urandom_range(1, 16));
        gain_list[9] = 16'($urandom);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // every path entry is written before any sample reads it
        for (int p = 0; p < MAX_PATHS; p++)
            push_load(p, edge_angle(p), edge_angle(p + 3), edge_angle(p + 5));
        push_sample(32'd12345);
        settle();

        program_regs(32'hFFFF_FFFF, 5'd16, 16'd32768);
        push_sample(32'd0);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'd1);
        push_sample(32'h8000_0000);
        push_load(3, 16'hFFFF, 16'h0000, 16'hFFFF);
        push_sample(TIME_W'($urandom));
        settle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            program_regs(dop_list[ph], cnt_list[ph], gain_list[ph]);
            src_pct <= (ph >= N_PHASES - 2) ? 0 : ((ph % 3 == 1) ? 0 : 6 + 4 * (ph % 3));
            sink_pct <= (ph >= N_PHASES - 2) ? 0 : ((ph % 4 == 2) ? 0 : 5 + 3 * (ph % 4));
            add_random(ITEMS_PER_PHASE);
            settle();
        end

        $display("covered %0d path loads and %0d fade samples, %0d results checked",
                 n_loads, n_samples, results_seen);
        $display("across %0d register settings incl. zero/over-range path counts and gains",
                 n_settings);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
